@@ rtl/tlrp_pkg.sv @@
// shared widths, codes and interface types of the traffic light roi projection unit
package tlrp_pkg;

  localparam int PosW  = 40;  // map coordinates, Q24.16
  localparam int QuatW = 32;  // quaternion and lens values
  localparam int MarW  = 31;  // margin registers
  localparam int ImgW  = 14;  // pixel coordinates
  localparam int DiffW = 42;  // point minus camera position
  localparam int RotW  = 33;  // rotation entry, Q3.30 saturated to +-2.0
  localparam int PixW  = 30;  // clamped pixel position, Q14.16
  localparam int CfgIdxW = 3;

  // frame parameter index codes
  localparam logic [3:0] PrmPosX  = 4'd0;
  localparam logic [3:0] PrmPosY  = 4'd1;
  localparam logic [3:0] PrmPosZ  = 4'd2;
  localparam logic [3:0] PrmQuatX = 4'd3;
  localparam logic [3:0] PrmQuatY = 4'd4;
  localparam logic [3:0] PrmQuatZ = 4'd5;
  localparam logic [3:0] PrmQuatW = 4'd6;
  localparam logic [3:0] PrmFx    = 4'd7;
  localparam logic [3:0] PrmFy    = 4'd8;
  localparam logic [3:0] PrmCx    = 4'd9;
  localparam logic [3:0] PrmCy    = 4'd10;

  // register index codes
  localparam logic [CfgIdxW-1:0] CfgSinYaw   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSinPitch = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHalfW    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHalfH    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHalfD    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgImgW     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgImgH     = 3'd6;

  localparam logic signed [QuatW-1:0] QuatOne = 32'sd1073741824;

  typedef struct packed {
    logic [MarW-1:0]         sin_yaw;
    logic [MarW-1:0]         sin_pitch;
    logic [MarW-1:0]         half_w;
    logic [MarW-1:0]         half_h;
    logic [MarW-1:0]         half_d;
    logic [ImgW-1:0]         img_w;
    logic [ImgW-1:0]         img_h;
    logic signed [QuatW-1:0] fx;
    logic signed [QuatW-1:0] fy;
    logic signed [QuatW-1:0] cx;
    logic signed [QuatW-1:0] cy;
  } lane_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ok;
  } lane_stat_t;

endpackage

@@ rtl/traffic_light_roi_projection_unit.sv @@
// top level of the traffic light roi projection unit: state, two lanes, box merge
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | sink      | in_valid_i/in_ready_o  | command, param_index/value, points, id
//  out     | source    | out_valid_o/out_ready_i| roi_valid, roi_x/y/width/height, roi_id
//  cfg     | sink      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// a set-up beat is written at once and the unit is ready again at once
// a project beat first builds the rotation matrix, then runs both
//   corner lanes in parallel, each with its multiply terms on its own multiplier and
//   two 32-step restoring divisions
// reset puts the pose to the identity quaternion at the origin and lens values to zero
// the result waits in an output register; the next beat is taken meanwhile, and a
//   finished box stalls in the merge step only while that register is still full
module traffic_light_roi_projection_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [3:0]          param_index_i,
  input  logic signed [39:0]  param_value_i,
  input  logic signed [39:0]  left_x_i,
  input  logic signed [39:0]  left_y_i,
  input  logic signed [39:0]  left_z_i,
  input  logic signed [39:0]  right_x_i,
  input  logic signed [39:0]  right_y_i,
  input  logic signed [39:0]  right_z_i,
  input  logic [30:0]         lamp_height_i,
  input  logic [31:0]         lamp_id_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                roi_valid_o,
  output logic [13:0]         roi_x_o,
  output logic [13:0]         roi_y_o,
  output logic [13:0]         roi_width_o,
  output logic [13:0]         roi_height_o,
  output logic [31:0]         roi_id_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [30:0]         cfg_data_i
);

  // top sequencer codes
  localparam logic [1:0] TIdle  = 2'd0;
  localparam logic [1:0] TRot   = 2'd1;
  localparam logic [1:0] TLane  = 2'd2;
  localparam logic [1:0] TMerge = 2'd3;

  logic [1:0] st_q;

  // configuration registers
  logic [30:0] sin_yaw_q, sin_pitch_q, half_w_q, half_h_q, half_d_q;
  logic [13:0] img_w_q, img_h_q;

  // frame state
  logic signed [39:0] pos_q [3];
  logic signed [31:0] quat_q [4];
  logic signed [31:0] lens_q [4];

  // latched corner offsets from the camera, and the id
  logic signed [41:0] dl_q [3];
  logic signed [41:0] dr_q [3];
  logic [31:0]        id_q;

  logic               in_fire, proj_fire, setup_fire;
  logic               rot_done, lane_start;
  logic [8:0][32:0]   rot;
  tlrp_pkg::lane_cfg_t  lane_cfg;
  tlrp_pkg::lane_stat_t tl_stat, br_stat;
  logic [29:0]        tl_u, tl_v, br_u, br_v;

  // output register
  logic               out_valid_q;
  logic               roi_valid_q;
  logic [13:0]        roi_x_q, roi_y_q, roi_w_q, roi_h_q;
  logic [31:0]        roi_id_q;
  logic               out_load;

  assign in_ready_o  = (st_q == TIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign proj_fire   = in_fire && command_i;
  assign setup_fire  = in_fire && !command_i;
  assign cfg_ready_o = 1'b1;
  assign lane_start  = (st_q == TRot) && rot_done;
  assign out_load    = (st_q == TMerge) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= TIdle;
    end else begin
      case (st_q)
        TIdle:  if (proj_fire) st_q <= TRot;
        TRot:   if (rot_done) st_q <= TLane;
        TLane:  if (tl_stat.done && br_stat.done) st_q <= TMerge;
        TMerge: if (out_load) st_q <= TIdle;
        default: st_q <= TIdle;
      endcase
    end
  end

  // register writes, each masked to the register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_yaw_q   <= '0;
      sin_pitch_q <= '0;
      half_w_q    <= '0;
      half_h_q    <= '0;
      half_d_q    <= '0;
      img_w_q     <= 14'd1920;
      img_h_q     <= 14'd1080;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tlrp_pkg::CfgSinYaw:   sin_yaw_q   <= cfg_data_i;
        tlrp_pkg::CfgSinPitch: sin_pitch_q <= cfg_data_i;
        tlrp_pkg::CfgHalfW:    half_w_q    <= cfg_data_i;
        tlrp_pkg::CfgHalfH:    half_h_q    <= cfg_data_i;
        tlrp_pkg::CfgHalfD:    half_d_q    <= cfg_data_i;
        tlrp_pkg::CfgImgW:     img_w_q     <= cfg_data_i[13:0];
        tlrp_pkg::CfgImgH:     img_h_q     <= cfg_data_i[13:0];
        default: begin
        end
      endcase
    end
  end

  // frame parameter writes; unknown indices are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0]  <= '0;
      pos_q[1]  <= '0;
      pos_q[2]  <= '0;
      quat_q[0] <= '0;
      quat_q[1] <= '0;
      quat_q[2] <= '0;
      quat_q[3] <= tlrp_pkg::QuatOne;
      lens_q[0] <= '0;
      lens_q[1] <= '0;
      lens_q[2] <= '0;
      lens_q[3] <= '0;
    end else if (setup_fire) begin
      case (param_index_i)
        tlrp_pkg::PrmPosX:  pos_q[0]  <= param_value_i;
        tlrp_pkg::PrmPosY:  pos_q[1]  <= param_value_i;
        tlrp_pkg::PrmPosZ:  pos_q[2]  <= param_value_i;
        tlrp_pkg::PrmQuatX: quat_q[0] <= param_value_i[31:0];
        tlrp_pkg::PrmQuatY: quat_q[1] <= param_value_i[31:0];
        tlrp_pkg::PrmQuatZ: quat_q[2] <= param_value_i[31:0];
        tlrp_pkg::PrmQuatW: quat_q[3] <= param_value_i[31:0];
        tlrp_pkg::PrmFx:    lens_q[0] <= param_value_i[31:0];
        tlrp_pkg::PrmFy:    lens_q[1] <= param_value_i[31:0];
        tlrp_pkg::PrmCx:    lens_q[2] <= param_value_i[31:0];
        tlrp_pkg::PrmCy:    lens_q[3] <= param_value_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // top-left corner is the left point raised by the housing height
  always_ff @(posedge clk_i) begin
    if (proj_fire) begin
      dl_q[0] <= 42'(left_x_i) - 42'(pos_q[0]);
      dl_q[1] <= 42'(left_y_i) - 42'(pos_q[1]);
      dl_q[2] <= 42'(left_z_i) + $signed({11'b0, lamp_height_i}) - 42'(pos_q[2]);
      dr_q[0] <= 42'(right_x_i) - 42'(pos_q[0]);
      dr_q[1] <= 42'(right_y_i) - 42'(pos_q[1]);
      dr_q[2] <= 42'(right_z_i) - 42'(pos_q[2]);
      id_q    <= lamp_id_i;
    end
  end

  tlrp_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (proj_fire),
    .qx_i    (quat_q[0]),
    .qy_i    (quat_q[1]),
    .qz_i    (quat_q[2]),
    .qw_i    (quat_q[3]),
    .rot_o   (rot),
    .done_o  (rot_done)
  );

  always_comb begin
    lane_cfg.sin_yaw   = sin_yaw_q;
    lane_cfg.sin_pitch = sin_pitch_q;
    lane_cfg.half_w    = half_w_q;
    lane_cfg.half_h    = half_h_q;
    lane_cfg.half_d    = half_d_q;
    lane_cfg.img_w     = img_w_q;
    lane_cfg.img_h     = img_h_q;
    lane_cfg.fx        = lens_q[0];
    lane_cfg.fy        = lens_q[1];
    lane_cfg.cx        = lens_q[2];
    lane_cfg.cy        = lens_q[3];
  end

  // top-left lane widens outward
  tlrp_lane u_lane_tl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .inward_i (1'b0),
    .d0_i     (dl_q[0]),
    .d1_i     (dl_q[1]),
    .d2_i     (dl_q[2]),
    .rot_i    (rot),
    .cfg_i    (lane_cfg),
    .stat_o   (tl_stat),
    .u_o      (tl_u),
    .v_o      (tl_v)
  );

  // bottom-right lane adds the margins and so also widens outward
  tlrp_lane u_lane_br (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .inward_i (1'b1),
    .d0_i     (dr_q[0]),
    .d1_i     (dr_q[1]),
    .d2_i     (dr_q[2]),
    .rot_i    (rot),
    .cfg_i    (lane_cfg),
    .stat_o   (br_stat),
    .u_o      (br_u),
    .v_o      (br_v)
  );

  // merge: whole pixels, signed extent, empty or behind-camera boxes are zeroed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [14:0] w, h;
    logic        ok;
    w  = {1'b0, br_u[29:16]} - {1'b0, tl_u[29:16]};
    h  = {1'b0, br_v[29:16]} - {1'b0, tl_v[29:16]};
    ok = tl_stat.ok && br_stat.ok && !w[14] && (w != '0) && !h[14] && (h != '0);
    if (out_load) begin
      roi_valid_q <= ok;
      roi_x_q     <= ok ? tl_u[29:16] : '0;
      roi_y_q     <= ok ? tl_v[29:16] : '0;
      roi_w_q     <= ok ? w[13:0] : '0;
      roi_h_q     <= ok ? h[13:0] : '0;
      roi_id_q    <= id_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign roi_valid_o  = roi_valid_q;
  assign roi_x_o      = roi_x_q;
  assign roi_y_o      = roi_y_q;
  assign roi_width_o  = roi_w_q;
  assign roi_height_o = roi_h_q;
  assign roi_id_o     = roi_id_q;

endmodule

@@ rtl/tlrp_rot.sv @@
// rotation matrix builder: quaternion products on one shared multiplier
module tlrp_rot (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [31:0]      qx_i,
  input  logic signed [31:0]      qy_i,
  input  logic signed [31:0]      qz_i,
  input  logic signed [31:0]      qw_i,
  output logic [8:0][32:0]        rot_o,
  output logic                    done_o
);

  localparam logic [3:0] LastProd = 4'd9;
  localparam logic signed [36:0] RLim = 37'sd2147483648;
  localparam logic signed [36:0] One37 = 37'sd1073741824;

  logic               busy_q;
  logic               done_q;
  logic [3:0]         cnt_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] prod_d;
  logic signed [31:0] op_a, op_b;
  logic signed [33:0] pr_q [9];

  function automatic logic [32:0] sat_rot(input logic signed [36:0] v);
    logic signed [36:0] r;
    r = v;
    if (v > RLim) r = RLim;
    else if (v < -RLim) r = -RLim;
    return r[32:0];
  endfunction

  // product order: xx yy zz xy xz yz wx wy wz
  always_comb begin
    op_a = qx_i;
    op_b = qx_i;
    case (cnt_q)
      4'd0: begin op_a = qx_i; op_b = qx_i; end
      4'd1: begin op_a = qy_i; op_b = qy_i; end
      4'd2: begin op_a = qz_i; op_b = qz_i; end
      4'd3: begin op_a = qx_i; op_b = qy_i; end
      4'd4: begin op_a = qx_i; op_b = qz_i; end
      4'd5: begin op_a = qy_i; op_b = qz_i; end
      4'd6: begin op_a = qw_i; op_b = qx_i; end
      4'd7: begin op_a = qw_i; op_b = qy_i; end
      4'd8: begin op_a = qw_i; op_b = qz_i; end
      default: begin op_a = qx_i; op_b = qx_i; end
    endcase
    prod_d = 64'(op_a) * 64'(op_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == LastProd) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      prod_q <= prod_d;
      if (cnt_q != 4'd0) pr_q[cnt_q - 4'd1] <= prod_q[63:30];
    end
  end

  always_comb begin
    logic signed [36:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    xx = 37'(pr_q[0]);
    yy = 37'(pr_q[1]);
    zz = 37'(pr_q[2]);
    xy = 37'(pr_q[3]);
    xz = 37'(pr_q[4]);
    yz = 37'(pr_q[5]);
    wx = 37'(pr_q[6]);
    wy = 37'(pr_q[7]);
    wz = 37'(pr_q[8]);
    rot_o[0] = sat_rot(One37 - 2 * (yy + zz));
    rot_o[1] = sat_rot(2 * (xy - wz));
    rot_o[2] = sat_rot(2 * (xz + wy));
    rot_o[3] = sat_rot(2 * (xy + wz));
    rot_o[4] = sat_rot(One37 - 2 * (xx + zz));
    rot_o[5] = sat_rot(2 * (yz - wx));
    rot_o[6] = sat_rot(2 * (xz - wy));
    rot_o[7] = sat_rot(2 * (yz + wx));
    rot_o[8] = sat_rot(One37 - 2 * (xx + yy));
  end

  assign done_o = done_q;

endmodule

@@ rtl/tlrp_lane.sv @@
// one projection lane: rotate, apply margins, divide and map through the lens
module tlrp_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  inward_i,
  input  logic signed [41:0]    d0_i,
  input  logic signed [41:0]    d1_i,
  input  logic signed [41:0]    d2_i,
  input  logic [8:0][32:0]      rot_i,
  input  tlrp_pkg::lane_cfg_t   cfg_i,
  output tlrp_pkg::lane_stat_t  stat_o,
  output logic [29:0]           u_o,
  output logic [29:0]           v_o
);

  localparam logic [2:0] LsIdle = 3'd0;
  localparam logic [2:0] LsMul  = 3'd1;
  localparam logic [2:0] LsAdj  = 3'd2;
  localparam logic [2:0] LsDivI = 3'd3;
  localparam logic [2:0] LsDivS = 3'd4;
  localparam logic [2:0] LsDivF = 3'd5;
  localparam logic [2:0] LsLens = 3'd6;
  localparam logic [2:0] LsDone = 3'd7;

  localparam logic [3:0] LastTerm = 4'd10;
  localparam logic signed [52:0] Sat40Hi = 53'sd549755813887;
  localparam logic signed [52:0] Sat40Lo = -53'sd549755813888;
  localparam logic [31:0] RatioLim = 32'h8000_0000;

  logic [2:0]          st_q;
  logic [3:0]          term_q;
  logic [1:0]          ph_q;
  logic [1:0]          lph_q;
  logic signed [51:0]  c0_q, c1_q, c2_q, mx_q, my_q;
  logic signed [67:0]  prod_q;
  logic signed [81:0]  p_q;
  logic signed [39:0]  x_q, y_q, z_q;
  logic                ok_q;
  logic                dsel_q;
  logic                neg_q;
  logic [39:0]         rem_q;
  logic [31:0]         num_q;
  logic [31:0]         quo_q;
  logic [4:0]          bit_q;
  logic signed [32:0]  ru_q, rv_q;
  logic [29:0]         u_q, v_q;

  logic signed [51:0]  a_sel;
  logic signed [33:0]  b_sel;
  logic signed [33:0]  mul_a, mul_b;
  logic signed [67:0]  mul_p;

  function automatic logic signed [39:0] sat40(input logic signed [52:0] v);
    logic signed [52:0] r;
    r = v;
    if (v > Sat40Hi) r = Sat40Hi;
    else if (v < Sat40Lo) r = Sat40Lo;
    return r[39:0];
  endfunction

  function automatic logic [29:0] clamp_px(input logic signed [51:0] v,
                                           input logic [13:0] img);
    logic signed [51:0] lim;
    logic signed [51:0] r;
    lim = $signed({22'b0, img, 16'b0});
    r = v;
    if (v < 52'sd0) r = '0;
    else if (v > lim) r = lim;
    return r[29:0];
  endfunction

  // operand pair of each multiply-accumulate term
  always_comb begin
    a_sel = '0;
    b_sel = '0;
    case (term_q)
      4'd0: begin a_sel = 52'(d0_i); b_sel = 34'($signed(rot_i[0])); end
      4'd1: begin a_sel = 52'(d1_i); b_sel = 34'($signed(rot_i[3])); end
      4'd2: begin a_sel = 52'(d2_i); b_sel = 34'($signed(rot_i[6])); end
      4'd3: begin a_sel = 52'(d0_i); b_sel = 34'($signed(rot_i[1])); end
      4'd4: begin a_sel = 52'(d1_i); b_sel = 34'($signed(rot_i[4])); end
      4'd5: begin a_sel = 52'(d2_i); b_sel = 34'($signed(rot_i[7])); end
      4'd6: begin a_sel = 52'(d0_i); b_sel = 34'($signed(rot_i[2])); end
      4'd7: begin a_sel = 52'(d1_i); b_sel = 34'($signed(rot_i[5])); end
      4'd8: begin a_sel = 52'(d2_i); b_sel = 34'($signed(rot_i[8])); end
      4'd9: begin a_sel = c2_q; b_sel = $signed({3'b0, cfg_i.sin_yaw}); end
      4'd10: begin a_sel = c2_q; b_sel = $signed({3'b0, cfg_i.sin_pitch}); end
      default: begin a_sel = '0; b_sel = '0; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      LsMul: begin
        if (ph_q == 2'd0) mul_a = 34'($signed(a_sel[51:20]));
        else mul_a = $signed({14'b0, a_sel[19:0]});
        mul_b = b_sel;
      end
      LsLens: begin
        mul_a = lph_q[1] ? 34'(rv_q) : 34'(ru_q);
        mul_b = lph_q[1] ? 34'($signed(cfg_i.fy)) : 34'($signed(cfg_i.fx));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 68'(mul_a) * 68'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= LsIdle;
      term_q <= '0;
      ph_q   <= '0;
      lph_q  <= '0;
      ok_q   <= 1'b0;
      dsel_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      case (st_q)
        LsIdle, LsDone: begin
          if (start_i) begin
            st_q   <= LsMul;
            term_q <= '0;
            ph_q   <= '0;
            ok_q   <= 1'b0;
          end
        end
        LsMul: begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == 2'd3) begin
            term_q <= term_q + 4'd1;
            if (term_q == LastTerm) st_q <= LsAdj;
          end
        end
        LsAdj: begin
          if (sat40(53'(c2_q) - 53'($signed({1'b0, cfg_i.half_d}))) <= 40'sd0) begin
            ok_q <= 1'b0;
            st_q <= LsDone;
          end else begin
            dsel_q <= 1'b0;
            st_q   <= LsDivI;
          end
        end
        LsDivI: begin
          bit_q <= 5'd31;
          st_q  <= LsDivS;
        end
        LsDivS: begin
          bit_q <= bit_q - 5'd1;
          if (bit_q == 5'd0) st_q <= LsDivF;
        end
        LsDivF: begin
          if (!dsel_q) begin
            dsel_q <= 1'b1;
            st_q   <= LsDivI;
          end else begin
            lph_q <= '0;
            st_q  <= LsLens;
          end
        end
        LsLens: begin
          lph_q <= lph_q + 2'd1;
          if (lph_q == 2'd3) begin
            ok_q <= 1'b1;
            st_q <= LsDone;
          end
        end
        default: st_q <= LsIdle;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    logic signed [39:0] n;
    logic [39:0]        mag;
    logic [40:0]        trial;
    logic [31:0]        qmag;
    n     = dsel_q ? y_q : x_q;
    mag   = n[39] ? 40'(-n) : 40'(n);
    trial = {rem_q, num_q[31]};
    qmag  = (quo_q > RatioLim) ? RatioLim : quo_q;
    case (st_q)
      LsIdle, LsDone: begin
        if (start_i) begin
          c0_q <= '0;
          c1_q <= '0;
          c2_q <= '0;
          mx_q <= 52'($signed({1'b0, cfg_i.half_w}));
          my_q <= 52'($signed({1'b0, cfg_i.half_h}));
        end
      end
      LsMul: begin
        case (ph_q)
          2'd0: prod_q <= mul_p;
          2'd1: begin
            prod_q <= mul_p;
            p_q    <= {prod_q[61:0], 20'b0};
          end
          2'd2: p_q <= p_q + 82'(prod_q);
          default: begin
            if (term_q < 4'd3) c0_q <= c0_q + p_q[81:30];
            else if (term_q < 4'd6) c1_q <= c1_q + p_q[81:30];
            else if (term_q < 4'd9) c2_q <= c2_q + p_q[81:30];
            else if (term_q == 4'd9) mx_q <= mx_q + p_q[81:30];
            else my_q <= my_q + p_q[81:30];
          end
        endcase
      end
      LsAdj: begin
        x_q <= inward_i ? sat40(53'(c0_q) + 53'(mx_q)) : sat40(53'(c0_q) - 53'(mx_q));
        y_q <= inward_i ? sat40(53'(c1_q) + 53'(my_q)) : sat40(53'(c1_q) - 53'(my_q));
        z_q <= sat40(53'(c2_q) - 53'($signed({1'b0, cfg_i.half_d})));
      end
      LsDivI: begin
        neg_q <= n[39];
        rem_q <= {16'b0, mag[39:16]};
        num_q <= {mag[15:0], 16'b0};
        // quotient of 2^32 or more saturates anyway
        if ({16'b0, mag} >= {z_q[39:0], 16'b0}) quo_q <= '1;
        else quo_q <= '0;
      end
      LsDivS: begin
        if (quo_q != '1 || rem_q != '0 || num_q != '0) begin
          num_q <= {num_q[30:0], 1'b0};
          if (trial >= {1'b0, z_q[39:0]}) begin
            rem_q <= 40'(trial - {1'b0, z_q[39:0]});
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= trial[39:0];
            quo_q <= {quo_q[30:0], 1'b0};
          end
        end
      end
      LsDivF: begin
        if (!dsel_q) ru_q <= neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
        else rv_q <= neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      end
      LsLens: begin
        case (lph_q)
          2'd0, 2'd2: prod_q <= mul_p;
          2'd1: u_q <= clamp_px($signed(prod_q[67:16]) + 52'($signed(cfg_i.cx)), cfg_i.img_w);
          default: v_q <= clamp_px($signed(prod_q[67:16]) + 52'($signed(cfg_i.cy)),
                                   cfg_i.img_h);
        endcase
      end
      default: begin
      end
    endcase
  end

  assign stat_o.busy = (st_q != LsIdle) && (st_q != LsDone);
  assign stat_o.done = (st_q == LsDone);
  assign stat_o.ok   = ok_q;
  assign u_o = u_q;
  assign v_o = v_q;

endmodule

@@ rtl/tlrp_checker.sv @@
// port-level checks of the traffic light roi projection unit and their binding
module tlrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        command_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        roi_valid_o,
  input logic [13:0] roi_x_o,
  input logic [13:0] roi_y_o,
  input logic [13:0] roi_width_o,
  input logic [13:0] roi_height_o,
  input logic [31:0] roi_id_o
);

  // a stalled result beat stays valid and keeps its id, x, width and valid flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(roi_id_o) &&
      $stable(roi_x_o) && $stable(roi_width_o) && $stable(roi_valid_o))
    else $error("result beat changed while stalled");

  // a project beat occupies the unit
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i |=> !in_ready_o)
    else $error("unit took a beat while projecting");

  // a valid box is never empty
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && roi_valid_o |-> roi_width_o != '0 && roi_height_o != '0)
    else $error("valid box with zero extent");

  // an invalid box reports zeros
  a_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !roi_valid_o |-> roi_x_o == '0 && roi_y_o == '0 &&
      roi_width_o == '0 && roi_height_o == '0)
    else $error("invalid box with nonzero fields");

endmodule

bind traffic_light_roi_projection_unit tlrp_checker u_tlrp_checker (.*);

@@ bench/traffic_light_roi_projection_unit_chk.sv @@
// checker of the roi projection unit: mirrors pose, lens and margins, predicts each box, compares
`timescale 1ns / 100ps
module traffic_light_roi_projection_unit_chk
  import tlrp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               command_i,
  input  logic [3:0]         param_index_i,
  input  logic signed [39:0] param_value_i,
  input  logic signed [39:0] left_x_i,
  input  logic signed [39:0] left_y_i,
  input  logic signed [39:0] left_z_i,
  input  logic signed [39:0] right_x_i,
  input  logic signed [39:0] right_y_i,
  input  logic signed [39:0] right_z_i,
  input  logic [30:0]        lamp_height_i,
  input  logic [31:0]        lamp_id_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               roi_valid_i,
  input  logic [13:0]        roi_x_i,
  input  logic [13:0]        roi_y_i,
  input  logic [13:0]        roi_width_i,
  input  logic [13:0]        roi_height_i,
  input  logic [31:0]        roi_id_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic        ok;
    logic [13:0] x;
    logic [13:0] y;
    logic [13:0] w;
    logic [13:0] h;
    logic [31:0] id;
  } roi_t;

  localparam longint OneQ30   = 64'sd1073741824;
  localparam longint PosMax   = 64'sd549755813887;
  localparam longint PosMin   = -64'sd549755813888;
  localparam longint RatioLim = 64'sd2147483648;

  longint cam_pos[3];
  longint cam_q[4];
  longint lens[4];
  longint m_yaw, m_pitch, m_hw, m_hh, m_hd, img_w, img_h;

  roi_t box_q[$];
  int   fails;

  assign fail_count_o = fails;
  assign pending_o    = box_q.size();

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor(a * b / 2^30) at full width
  function automatic longint mul_q30(longint a, longint b);
    logic signed [95:0] aw, bw, pw;
    aw = a;
    bw = b;
    pw = aw * bw;
    return longint'(pw >>> 30);
  endfunction

  function automatic bit to_pixel(input longint p[3], input bit inward,
                                  output longint u, output longint v);
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz, mx, my, px, py, pz, ru, rv;
    longint r[3][3];
    longint d[3];
    longint c[3];
    xx = (cam_q[0] * cam_q[0]) >>> 30;
    yy = (cam_q[1] * cam_q[1]) >>> 30;
    zz = (cam_q[2] * cam_q[2]) >>> 30;
    xy = (cam_q[0] * cam_q[1]) >>> 30;
    xz = (cam_q[0] * cam_q[2]) >>> 30;
    yz = (cam_q[1] * cam_q[2]) >>> 30;
    wx = (cam_q[3] * cam_q[0]) >>> 30;
    wy = (cam_q[3] * cam_q[1]) >>> 30;
    wz = (cam_q[3] * cam_q[2]) >>> 30;
    r[0][0] = clip(OneQ30 - 2 * (yy + zz), -2 * OneQ30, 2 * OneQ30);
    r[0][1] = clip(2 * (xy - wz), -2 * OneQ30, 2 * OneQ30);
    r[0][2] = clip(2 * (xz + wy), -2 * OneQ30, 2 * OneQ30);
    r[1][0] = clip(2 * (xy + wz), -2 * OneQ30, 2 * OneQ30);
    r[1][1] = clip(OneQ30 - 2 * (xx + zz), -2 * OneQ30, 2 * OneQ30);
    r[1][2] = clip(2 * (yz - wx), -2 * OneQ30, 2 * OneQ30);
    r[2][0] = clip(2 * (xz - wy), -2 * OneQ30, 2 * OneQ30);
    r[2][1] = clip(2 * (yz + wx), -2 * OneQ30, 2 * OneQ30);
    r[2][2] = clip(OneQ30 - 2 * (xx + yy), -2 * OneQ30, 2 * OneQ30);
    u = 0;
    v = 0;
    for (int i = 0; i < 3; i++) d[i] = p[i] - cam_pos[i];
    for (int i = 0; i < 3; i++)
      c[i] = mul_q30(d[0], r[0][i]) + mul_q30(d[1], r[1][i]) + mul_q30(d[2], r[2][i]);
    mx = mul_q30(c[2], m_yaw) + m_hw;
    my = mul_q30(c[2], m_pitch) + m_hh;
    px = clip(inward ? c[0] + mx : c[0] - mx, PosMin, PosMax);
    py = clip(inward ? c[1] + my : c[1] - my, PosMin, PosMax);
    pz = clip(c[2] - m_hd, PosMin, PosMax);
    if (pz <= 0) return 0;
    ru = clip((px * 65536) / pz, -RatioLim, RatioLim);
    rv = clip((py * 65536) / pz, -RatioLim, RatioLim);
    u = clip(((lens[0] * ru) >>> 16) + lens[2], 0, img_w * 65536);
    v = clip(((lens[1] * rv) >>> 16) + lens[3], 0, img_h * 65536);
    return 1;
  endfunction

  function automatic roi_t predict_box();
    roi_t   b;
    longint tl[3];
    longint br[3];
    longint u1, v1, u2, v2, bx, by, bw, bh;
    bit     ok;
    tl[0] = left_x_i;
    tl[1] = left_y_i;
    tl[2] = longint'(left_z_i) + longint'({33'd0, lamp_height_i});
    br[0] = right_x_i;
    br[1] = right_y_i;
    br[2] = right_z_i;
    bx = 0; by = 0; bw = 0; bh = 0;
    ok = to_pixel(tl, 1'b0, u1, v1);
    if (ok) ok = to_pixel(br, 1'b1, u2, v2);
    if (ok) begin
      bx = u1 >>> 16;
      by = v1 >>> 16;
      bw = (u2 >>> 16) - bx;
      bh = (v2 >>> 16) - by;
      ok = bw > 0 && bh > 0;
    end
    if (!ok) begin
      bx = 0; by = 0; bw = 0; bh = 0;
    end
    b.ok = ok;
    b.x  = bx[13:0];
    b.y  = by[13:0];
    b.w  = bw[13:0];
    b.h  = bh[13:0];
    b.id = lamp_id_i;
    return b;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    roi_t exp_b;
    if (!rst_ni) begin
      m_yaw <= 0; m_pitch <= 0; m_hw <= 0; m_hh <= 0; m_hd <= 0;
      img_w <= 1920; img_h <= 1080;
      for (int i = 0; i < 3; i++) cam_pos[i] <= 0;
      for (int i = 0; i < 4; i++) begin
        cam_q[i] <= 0;
        lens[i]  <= 0;
      end
      cam_q[3] <= OneQ30;
      box_q.delete();
      fails <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgSinYaw:   m_yaw   <= cfg_data_i;
          CfgSinPitch: m_pitch <= cfg_data_i;
          CfgHalfW:    m_hw    <= cfg_data_i;
          CfgHalfH:    m_hh    <= cfg_data_i;
          CfgHalfD:    m_hd    <= cfg_data_i;
          CfgImgW:     img_w   <= cfg_data_i[13:0];
          CfgImgH:     img_h   <= cfg_data_i[13:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (command_i) begin
          box_q.push_back(predict_box());
        end else begin
          case (param_index_i)
            PrmPosX:  cam_pos[0] <= param_value_i;
            PrmPosY:  cam_pos[1] <= param_value_i;
            PrmPosZ:  cam_pos[2] <= param_value_i;
            PrmQuatX: cam_q[0] <= longint'(signed'(param_value_i[31:0]));
            PrmQuatY: cam_q[1] <= longint'(signed'(param_value_i[31:0]));
            PrmQuatZ: cam_q[2] <= longint'(signed'(param_value_i[31:0]));
            PrmQuatW: cam_q[3] <= longint'(signed'(param_value_i[31:0]));
            PrmFx:    lens[0] <= longint'(signed'(param_value_i[31:0]));
            PrmFy:    lens[1] <= longint'(signed'(param_value_i[31:0]));
            PrmCx:    lens[2] <= longint'(signed'(param_value_i[31:0]));
            PrmCy:    lens[3] <= longint'(signed'(param_value_i[31:0]));
            default: ;
          endcase
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (box_q.size() == 0) begin
          if (fails < 10) $display("unexpected result beat, id %h", roi_id_i);
          fails <= fails + 1;
        end else begin
          exp_b = box_q.pop_front();
          if (exp_b !== {roi_valid_i, roi_x_i, roi_y_i, roi_width_i, roi_height_i, roi_id_i})
          begin
            if (fails < 10)
              $display("box mismatch: exp ok %0d x %0d y %0d w %0d h %0d id %h, got ok %0d x %0d y %0d w %0d h %0d id %h",
                       exp_b.ok, exp_b.x, exp_b.y, exp_b.w, exp_b.h, exp_b.id,
                       roi_valid_i, roi_x_i, roi_y_i, roi_width_i, roi_height_i, roi_id_i);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

@@ bench/traffic_light_roi_projection_unit_tb.sv @@
// testbench top of the roi projection unit: reset, stimulus, idling, verdict
`timescale 1ns / 100ps
module traffic_light_roi_projection_unit_tb;
  import tlrp_pkg::*;

  localparam int     CycleLimit = 1500000;
  localparam int     DrainWait  = 300;
  localparam longint OneMeter   = 65536;

  logic               clk, rst_n;
  logic               in_valid, in_ready;
  logic               command;
  logic [3:0]         param_index;
  logic signed [39:0] param_value;
  logic signed [39:0] left_x, left_y, left_z, right_x, right_y, right_z;
  logic [30:0]        lamp_height;
  logic [31:0]        lamp_id;
  logic               out_valid, out_ready;
  logic               roi_valid;
  logic [13:0]        roi_x, roi_y, roi_width, roi_height;
  logic [31:0]        roi_id;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [30:0]        cfg_data;
  int                 fail_count, pending;
  int                 cycles;
  bit                 burst;      // stretch with no idling on either side

  traffic_light_roi_projection_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(command), .param_index_i(param_index), .param_value_i(param_value),
    .left_x_i(left_x), .left_y_i(left_y), .left_z_i(left_z),
    .right_x_i(right_x), .right_y_i(right_y), .right_z_i(right_z),
    .lamp_height_i(lamp_height), .lamp_id_i(lamp_id),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .roi_valid_o(roi_valid), .roi_x_o(roi_x), .roi_y_o(roi_y),
    .roi_width_o(roi_width), .roi_height_o(roi_height), .roi_id_o(roi_id),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  traffic_light_roi_projection_unit_chk chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .command_i(command), .param_index_i(param_index), .param_value_i(param_value),
    .left_x_i(left_x), .left_y_i(left_y), .left_z_i(left_z),
    .right_x_i(right_x), .right_y_i(right_y), .right_z_i(right_z),
    .lamp_height_i(lamp_height), .lamp_id_i(lamp_id),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .roi_valid_i(roi_valid), .roi_x_i(roi_x), .roi_y_i(roi_y),
    .roi_width_i(roi_width), .roi_height_i(roi_height), .roi_id_i(roi_id),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock, period 20 ns
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // random 40-bit word, every bit free
  function automatic logic [39:0] rand40();
    return {$urandom, $urandom};
  endfunction

  // signed value in [lo, hi]
  function automatic longint rand_span(longint lo, longint hi);
    longint unsigned r;
    r = {$urandom, $urandom};
    return lo + longint'(r % longint'(hi - lo + 1));
  endfunction

  // one beat on the item channel; valid is only lowered when a gap follows
  task automatic send_beat(bit cmd, logic [3:0] idx, logic [39:0] val,
                           logic [39:0] lx, logic [39:0] ly, logic [39:0] lz,
                           logic [39:0] rx, logic [39:0] ry, logic [39:0] rz,
                           logic [30:0] h, logic [31:0] id);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    param_index <= idx;
    param_value <= val;
    left_x      <= lx;
    left_y      <= ly;
    left_z      <= lz;
    right_x     <= rx;
    right_y     <= ry;
    right_z     <= rz;
    lamp_height <= h;
    lamp_id     <= id;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // set-up beat; the unused point fields carry noise
  task automatic set_param(logic [3:0] idx, logic [39:0] val);
    send_beat(1'b0, idx, val, rand40(), rand40(), rand40(), rand40(), rand40(), rand40(),
              $urandom, $urandom);
  endtask

  task automatic project(logic [39:0] lx, logic [39:0] ly, logic [39:0] lz,
                         logic [39:0] rx, logic [39:0] ry, logic [39:0] rz,
                         logic [30:0] h);
    send_beat(1'b1, $urandom, rand40(), lx, ly, lz, rx, ry, rz, h, $urandom);
  endtask

  // plausible camera: near identity pose, 500 to 1500 px focal, roughly centered
  task automatic plain_camera();
    set_param(PrmPosX, 40'(rand_span(-2 * OneMeter, 2 * OneMeter)));
    set_param(PrmPosY, 40'(rand_span(-2 * OneMeter, 2 * OneMeter)));
    set_param(PrmPosZ, 40'(rand_span(-2 * OneMeter, 2 * OneMeter)));
    set_param(PrmQuatX, 40'(rand_span(-(1 << 25), 1 << 25)));
    set_param(PrmQuatY, 40'(rand_span(-(1 << 25), 1 << 25)));
    set_param(PrmQuatZ, 40'(rand_span(-(1 << 25), 1 << 25)));
    set_param(PrmQuatW, 40'(QuatOne));
    set_param(PrmFx, 40'(rand_span(500, 1500) * OneMeter));
    set_param(PrmFy, 40'(rand_span(500, 1500) * OneMeter));
    set_param(PrmCx, 40'(rand_span(600, 1300) * OneMeter));
    set_param(PrmCy, 40'(rand_span(300, 800) * OneMeter));
  endtask

  // well formed light in front of the camera, random size and place
  task automatic plain_light();
    longint lx, ly, lz;
    lx = rand_span(-6 * OneMeter, 6 * OneMeter);
    ly = rand_span(-4 * OneMeter, 4 * OneMeter);
    lz = rand_span(3 * OneMeter, 80 * OneMeter);
    project(40'(lx), 40'(ly), 40'(lz),
            40'(lx + rand_span(-OneMeter / 4, 2 * OneMeter)),
            40'(ly + rand_span(-OneMeter / 4, 2 * OneMeter)),
            40'(lz + rand_span(-OneMeter, OneMeter)),
            31'(rand_span(0, 2 * OneMeter)));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // registers only change while nothing is in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_margins(logic [30:0] yaw, logic [30:0] pitch, logic [30:0] hw,
                               logic [30:0] hh, logic [30:0] hd,
                               logic [30:0] iw, logic [30:0] ih);
    write_reg(CfgSinYaw, yaw);
    write_reg(CfgSinPitch, pitch);
    write_reg(CfgHalfW, hw);
    write_reg(CfgHalfH, hh);
    write_reg(CfgHalfD, hd);
    write_reg(CfgImgW, iw);
    write_reg(CfgImgH, ih);
  endtask

  // receiver: random stall per beat, one long hold-off to back the unit up
  initial begin : receiver
    int stall, beats;
    out_ready = 1'b0;
    beats = 0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (beats == 120) stall = 4000;
      else stall = burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
      beats++;
    end
  end

  initial begin : stimulus
    int pick;
    cycles      = 0;
    burst       = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    command     = 1'b0;
    param_index = '0;
    param_value = '0;
    left_x      = '0;
    left_y      = '0;
    left_z      = '0;
    right_x     = '0;
    right_y     = '0;
    right_z     = '0;
    lamp_height = '0;
    lamp_id     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default pose and zero lens first
    project(40'(OneMeter), 40'(OneMeter), 40'(10 * OneMeter),
            40'(2 * OneMeter), 40'(2 * OneMeter), 40'(10 * OneMeter), 31'd0);
    plain_camera();
    // a visible light
    project(40'(-OneMeter / 2), 40'(-OneMeter), 40'(20 * OneMeter),
            40'(OneMeter / 2), 40'(OneMeter), 40'(20 * OneMeter), 31'(OneMeter));
    // depth not positive
    project(40'(0), 40'(0), 40'(-10 * OneMeter), 40'(OneMeter), 40'(OneMeter), 40'(0), 31'd0);
    // empty box: no width
    project(40'(OneMeter), 40'(0), 40'(30 * OneMeter),
            40'(OneMeter), 40'(OneMeter), 40'(30 * OneMeter), 31'd0);
    // field extremes
    send_beat(1'b1, 4'hf, {1'b0, {39{1'b1}}}, {1'b0, {39{1'b1}}}, {1'b0, {39{1'b1}}},
              {1'b0, {39{1'b1}}}, {1'b0, {39{1'b1}}}, {1'b0, {39{1'b1}}}, {1'b0, {39{1'b1}}},
              {31{1'b1}}, 32'hffffffff);
    send_beat(1'b1, 4'h0, {1'b1, 39'd0}, {1'b1, 39'd0}, {1'b1, 39'd0}, {1'b1, 39'd0},
              {1'b1, 39'd0}, {1'b1, 39'd0}, {1'b1, 39'd0}, 31'd0, 32'd0);
    project(40'(0), 40'(0), 40'(OneMeter), 40'(OneMeter), 40'(OneMeter), 40'(OneMeter),
            {31{1'b1}});
    // unknown parameter index leaves the pose alone
    set_param(4'd11, rand40());
    set_param(4'd15, {40{1'b1}});
    plain_light();
    // position and lens extremes
    set_param(PrmPosX, {1'b1, 39'd0});
    set_param(PrmFx, {8'h00, 1'b0, {31{1'b1}}});
    plain_light();
    set_param(PrmPosX, {1'b0, {39{1'b1}}});
    set_param(PrmQuatW, {8'hff, 1'b1, 31'd0});
    plain_light();

    // random phases, one register setting each
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: write_margins(31'(1 << 24), 31'(1 << 24), 31'(OneMeter / 8), 31'(OneMeter / 8),
                         31'(OneMeter / 4), 31'd1920, 31'd1080);
        1: write_margins(31'(1 << 30), 31'(1 << 30), {31{1'b1}}, {31{1'b1}}, {31{1'b1}},
                         31'd16383, 31'd16383);
        2: write_margins(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
        3: write_margins($urandom_range(0, 1 << 26), $urandom_range(0, 1 << 26),
                         $urandom_range(0, OneMeter), $urandom_range(0, OneMeter),
                         $urandom_range(0, OneMeter), $urandom, $urandom);
        default: write_margins($urandom, $urandom, $urandom_range(0, OneMeter / 2),
                               $urandom_range(0, OneMeter / 2),
                               $urandom_range(0, 2 * OneMeter), 31'd4095, 31'd2047);
      endcase
      write_reg(3'd7, $urandom);   // unused index
      plain_camera();
      for (int n = 0; n < 165; n++) begin
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        if (n % 55 == 54) plain_camera();
        pick = $urandom_range(0, 99);
        if (pick < 78) plain_light();
        else if (pick < 86) set_param($urandom_range(0, 15), rand40());
        else if (pick < 92) set_param($urandom_range(PrmQuatX, PrmQuatZ),
                                      40'(rand_span(-(1 << 26), 1 << 26)));
        else send_beat(1'b1, $urandom, rand40(), rand40(), rand40(), rand40(), rand40(),
                       rand40(), rand40(), $urandom, $urandom);
      end
      burst = 1'b0;
    end

    settle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tlrp_pkg.sv
rtl/tlrp_rot.sv
rtl/tlrp_lane.sv
rtl/traffic_light_roi_projection_unit.sv
rtl/tlrp_checker.sv
bench/traffic_light_roi_projection_unit_chk.sv
bench/traffic_light_roi_projection_unit_tb.sv
